@@ rtl/stack_with_search_defines.svh @@
// assertion macros for the stack with search block
`ifndef STACK_WITH_SEARCH_DEFINES_SVH
`define STACK_WITH_SEARCH_DEFINES_SVH

// property checked at every clock edge outside reset
`define SWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// implication whose property is checked in the cycle after the condition
`define SWS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ rtl/sws_pkg.sv @@
// shared types and codes of the stack with search block
package sws_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 5;

  localparam logic [CmdW-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CmdW-1:0] CMD_POP    = 2'd1;
  localparam logic [CmdW-1:0] CMD_SEARCH = 2'd2;

  localparam logic [StatusW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatusW-1:0] STAT_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] STAT_FULL  = 2'd2;
  localparam logic [StatusW-1:0] STAT_MISS  = 2'd3;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_LOAD_HIT,
    OP_SHIFT_HIT
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctl_t;

endpackage

@@ rtl/sws_cell.sv @@
// one stack cell: holds an entry and a compare flag, shifts with its neighbors
module sws_cell (
  input  logic                              clk_i,
  input  sws_pkg::cell_ctl_t                ctl_i,
  input  logic signed [sws_pkg::DataW-1:0]  up_value_i,
  input  logic signed [sws_pkg::DataW-1:0]  down_value_i,
  input  logic signed [sws_pkg::DataW-1:0]  key_i,
  input  logic                              down_hit_i,
  output logic signed [sws_pkg::DataW-1:0]  value_o,
  output logic                              hit_o
);

  logic signed [sws_pkg::DataW-1:0] value_q, value_d;
  logic                             hit_q, hit_d;

  always_comb begin
    value_d = value_q;
    hit_d   = hit_q;
    unique case (ctl_i.op)
      sws_pkg::OP_HOLD:      ;
      sws_pkg::OP_PUSH:      value_d = up_value_i;
      sws_pkg::OP_POP:       value_d = down_value_i;
      sws_pkg::OP_LOAD_HIT:  hit_d = (value_q == key_i);
      sws_pkg::OP_SHIFT_HIT: hit_d = down_hit_i;
      default:               ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    hit_q   <= hit_d;
  end

  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

@@ rtl/sws_ctrl.sv @@
// command sequencer, entry count and result register of the stack
`include "stack_with_search_defines.svh"

module sws_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [sws_pkg::CmdW-1:0]           cmd_i,
  input  logic signed [sws_pkg::DataW-1:0]   top_value_i,
  input  logic                               top_hit_i,
  output sws_pkg::cell_ctl_t                 cell_ctl_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sws_pkg::StatusW-1:0]        status_o,
  output logic signed [sws_pkg::DataW-1:0]   popped_value_o,
  output logic [sws_pkg::PosW-1:0]           found_position_o,
  output logic [sws_pkg::PosW-1:0]           entry_count_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(DEPTH);

  sws_pkg::state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic            out_valid_q, out_valid_d;

  logic [sws_pkg::StatusW-1:0]      status_q, res_status;
  logic signed [sws_pkg::DataW-1:0] popped_q, res_popped;
  logic [CntW-1:0]                  found_q, res_found;
  logic                             res_load;
  logic                             accept;
  logic                             scan_done;

  assign in_ready_o = (state_q == sws_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign scan_done  = top_hit_i || (pos_q == count_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sws_pkg::ST_IDLE: begin
        if (accept && (cmd_i == sws_pkg::CMD_SEARCH) && (count_q != '0)) begin
          state_d = sws_pkg::ST_SCAN;
        end
      end
      sws_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = sws_pkg::ST_IDLE;
        end
      end
      default: state_d = sws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cell_ctl_o.op = sws_pkg::OP_HOLD;
    count_d       = count_q;
    pos_d         = pos_q;
    res_load      = 1'b0;
    res_status    = sws_pkg::STAT_OK;
    res_popped    = '0;
    res_found     = '0;
    unique case (state_q)
      sws_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            sws_pkg::CMD_PUSH: begin
              res_load = 1'b1;
              if (count_q == Full) begin
                res_status = sws_pkg::STAT_FULL;
              end else begin
                cell_ctl_o.op = sws_pkg::OP_PUSH;
                count_d       = count_q + CntW'(1);
              end
            end
            sws_pkg::CMD_POP: begin
              res_load = 1'b1;
              if (count_q == '0) begin
                res_status = sws_pkg::STAT_EMPTY;
              end else begin
                cell_ctl_o.op = sws_pkg::OP_POP;
                res_popped    = top_value_i;
                count_d       = count_q - CntW'(1);
              end
            end
            sws_pkg::CMD_SEARCH: begin
              if (count_q == '0) begin
                res_load   = 1'b1;
                res_status = sws_pkg::STAT_EMPTY;
              end else begin
                cell_ctl_o.op = sws_pkg::OP_LOAD_HIT;
                pos_d         = CntW'(1);
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      sws_pkg::ST_SCAN: begin
        if (top_hit_i) begin
          res_load  = 1'b1;
          res_found = pos_q;
        end else if (pos_q == count_q) begin
          res_load   = 1'b1;
          res_status = sws_pkg::STAT_MISS;
        end else begin
          cell_ctl_o.op = sws_pkg::OP_SHIFT_HIT;
          pos_d         = pos_q + CntW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sws_pkg::ST_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      status_q <= res_status;
      popped_q <= res_popped;
      found_q  <= res_found;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign popped_value_o   = popped_q;
  assign found_position_o = sws_pkg::PosW'(found_q);
  assign entry_count_o    = sws_pkg::PosW'(count_q);

  `SWS_ASSERT(a_count_bound, count_q <= Full, "entry count above depth")
  `SWS_ASSERT(a_scan_out_free, (state_q != sws_pkg::ST_SCAN) || !out_valid_q,
              "result pending during search scan")
  `SWS_ASSERT(a_scan_pos, (state_q != sws_pkg::ST_SCAN) || ((pos_q != '0) && (pos_q <= count_q)),
              "scan position outside held entries")
  `SWS_ASSERT_NEXT(a_push_count,
                   accept && (cmd_i == sws_pkg::CMD_PUSH) && (count_q != Full),
                   count_q == $past(count_q) + CntW'(1), "push did not raise count")

endmodule

@@ rtl/stack_with_search.sv @@
// top level of the bounded stack with search
//
// Input channel in_valid_i/in_ready_o carries one command item: cmd_i selects
// push, pop or search, with push_value_i and search_key_i as operands.
// Output channel out_valid_o/out_ready_i returns one result item per command:
// status, popped value, found position (1 is top) and entry count after it.
// Entries live in a row of DEPTH cells, the top in cell 0; push and pop shift
// the whole row by one cell at once. For push, pop and unused codes the
// result is valid the cycle after acceptance. Search first compares all
// cells at once, then shifts the match flags toward cell 0 one cell a cycle
// until a hit or the count is met.
// A new command is taken while the previous result is being taken in the
// same cycle; a stalled receiver holds the result and blocks new commands.
// Reset clears the entry count and control; entry contents are not cleared.
module stack_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sws_pkg::CmdW-1:0]          cmd_i,
  input  logic signed [sws_pkg::DataW-1:0]  push_value_i,
  input  logic signed [sws_pkg::DataW-1:0]  search_key_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sws_pkg::StatusW-1:0]       status_o,
  output logic signed [sws_pkg::DataW-1:0]  popped_value_o,
  output logic [sws_pkg::PosW-1:0]          found_position_o,
  output logic [sws_pkg::PosW-1:0]          entry_count_o
);

  sws_pkg::cell_ctl_t cell_ctl;

  logic signed [sws_pkg::DataW-1:0] value [DEPTH];
  logic                             hit   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [sws_pkg::DataW-1:0] up_value;
    logic signed [sws_pkg::DataW-1:0] down_value;
    logic                             down_hit;

    if (i == 0) begin : g_top
      assign up_value = push_value_i;
    end else begin : g_mid
      assign up_value = value[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign down_value = '0;
      assign down_hit   = 1'b0;
    end else begin : g_inner
      assign down_value = value[i+1];
      assign down_hit   = hit[i+1];
    end

    sws_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (cell_ctl),
      .up_value_i   (up_value),
      .down_value_i (down_value),
      .key_i        (search_key_i),
      .down_hit_i   (down_hit),
      .value_o      (value[i]),
      .hit_o        (hit[i])
    );
  end

  sws_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .top_value_i      (value[0]),
    .top_hit_i        (hit[0]),
    .cell_ctl_o       (cell_ctl),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .popped_value_o   (popped_value_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o)
  );

endmodule

@@ tb/tb_stack_with_search.sv @@
// testbench of the stack with search: random and directed commands checked against a shadow stack
`timescale 1ns / 1ps

module tb_stack_with_search;

  localparam int unsigned StackDepth = 16;
  localparam logic [sws_pkg::CmdW-1:0] CmdUnused = 2'd3;
  localparam int RandomItems = 1800;
  localparam int QuietFrom = 2400;
  localparam int QuietTo = 3300;

  typedef struct {
    logic [sws_pkg::CmdW-1:0]  cmd;
    logic [sws_pkg::DataW-1:0] push_value;
    logic [sws_pkg::DataW-1:0] search_key;
    bit                        drain;
  } stack_cmd_t;

  typedef struct {
    logic [sws_pkg::StatusW-1:0] status;
    logic [sws_pkg::DataW-1:0]   popped;
    logic [sws_pkg::PosW-1:0]    position;
    logic [sws_pkg::PosW-1:0]    count;
  } stack_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [sws_pkg::CmdW-1:0] cmd_i = '0;
  logic [sws_pkg::DataW-1:0] push_value_i = '0;
  logic [sws_pkg::DataW-1:0] search_key_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [sws_pkg::StatusW-1:0] status_o;
  logic [sws_pkg::DataW-1:0] popped_value_o;
  logic [sws_pkg::PosW-1:0] found_position_o;
  logic [sws_pkg::PosW-1:0] entry_count_o;

  stack_cmd_t pending_items[$];
  stack_result_t expected_results[$];
  logic [sws_pkg::DataW-1:0] gen_contents[$];

  logic [sws_pkg::DataW-1:0] model_stack[StackDepth];
  int model_count = 0;
  int errors = 0;
  logic in_taken = 1'b0;
  int tx_cycle = 0;
  int rx_cycle = 0;
  int hold_left = 0;

  stack_with_search #(.DEPTH(StackDepth)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .cmd_i(cmd_i),
    .push_value_i(push_value_i),
    .search_key_i(search_key_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o(status_o),
    .popped_value_o(popped_value_o),
    .found_position_o(found_position_o),
    .entry_count_o(entry_count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic stack_result_t predict_stack_result(logic [sws_pkg::CmdW-1:0] cmd,
                                                         logic [sws_pkg::DataW-1:0] pval,
                                                         logic [sws_pkg::DataW-1:0] key);
    stack_result_t r;
    int idx;
    r = '{status: sws_pkg::STAT_OK, popped: '0, position: '0, count: '0};
    case (cmd)
      sws_pkg::CMD_PUSH: begin
        if (model_count >= StackDepth) begin
          r.status = sws_pkg::STAT_FULL;
        end else begin
          model_stack[model_count] = pval;
          model_count++;
        end
      end
      sws_pkg::CMD_POP: begin
        if (model_count == 0) begin
          r.status = sws_pkg::STAT_EMPTY;
        end else begin
          model_count--;
          r.popped = model_stack[model_count];
        end
      end
      sws_pkg::CMD_SEARCH: begin
        if (model_count == 0) begin
          r.status = sws_pkg::STAT_EMPTY;
        end else begin
          r.status = sws_pkg::STAT_MISS;
          for (idx = model_count - 1; idx >= 0; idx--) begin
            if (model_stack[idx] == key) begin
              r.status = sws_pkg::STAT_OK;
              r.position = sws_pkg::PosW'(model_count - idx);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    r.count = sws_pkg::PosW'(model_count);
    return r;
  endfunction

  task automatic compare_field(string name, logic [sws_pkg::DataW-1:0] want,
                               logic [sws_pkg::DataW-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic add_item(logic [sws_pkg::CmdW-1:0] cmd, logic [sws_pkg::DataW-1:0] pval,
                          logic [sws_pkg::DataW-1:0] key, bit drain = 1'b0);
    pending_items.push_back('{cmd: cmd, push_value: pval, search_key: key, drain: drain});
    if (cmd == sws_pkg::CMD_PUSH && gen_contents.size() < StackDepth)
      gen_contents.push_back(pval);
    if (cmd == sws_pkg::CMD_POP && gen_contents.size() > 0) void'(gen_contents.pop_back());
  endtask

  function automatic logic [sws_pkg::DataW-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 3);
    case (sel)
      0: return $urandom_range(0, 7);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [sws_pkg::DataW-1:0] pick_key();
    if (gen_contents.size() > 0 && $urandom_range(0, 99) < 65)
      return gen_contents[$urandom_range(0, gen_contents.size() - 1)];
    return pick_value();
  endfunction

  // result check first, then prediction of the item taken at this edge
  always @(posedge clk_i) begin
    stack_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, status %0h count %0h", $time,
                   status_o, entry_count_o);
        end else begin
          want = expected_results.pop_front();
          compare_field("status", sws_pkg::DataW'(want.status), sws_pkg::DataW'(status_o));
          compare_field("popped_value", want.popped, popped_value_o);
          compare_field("found_position", sws_pkg::DataW'(want.position),
                        sws_pkg::DataW'(found_position_o));
          compare_field("entry_count", sws_pkg::DataW'(want.count),
                        sws_pkg::DataW'(entry_count_o));
        end
      end
      if (in_valid_i && in_ready_o)
        expected_results.push_back(predict_stack_result(cmd_i, push_value_i, search_key_i));
    end
    in_taken <= rst_ni && in_valid_i && in_ready_o;
  end

  always @(negedge clk_i) begin
    stack_cmd_t item;
    if (rst_ni) begin
      tx_cycle++;
      if (!in_valid_i || in_taken) begin
        if (pending_items.size() != 0 &&
            (!pending_items[0].drain || expected_results.size() == 0) &&
            ((tx_cycle >= QuietFrom && tx_cycle < QuietTo) || $urandom_range(0, 99) >= 21)) begin
          item = pending_items.pop_front();
          in_valid_i <= 1'b1;
          cmd_i <= item.cmd;
          push_value_i <= item.push_value;
          search_key_i <= item.search_key;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-offs stall the block while the sender keeps offering
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (rx_cycle == 1500 || rx_cycle == 3600) hold_left = 120;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_cycle >= QuietFrom && rx_cycle < QuietTo) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= 21);
      end
    end
  end

  initial begin
    int n;
    int mode_left;
    int push_bias;
    int unsigned roll;
    logic [sws_pkg::CmdW-1:0] cmd;

    add_item(sws_pkg::CMD_POP, $urandom, $urandom);
    add_item(sws_pkg::CMD_SEARCH, $urandom, 32'h0000_0000);
    add_item(CmdUnused, $urandom, $urandom);
    add_item(sws_pkg::CMD_PUSH, 32'h7fff_ffff, $urandom);
    add_item(sws_pkg::CMD_PUSH, 32'h8000_0000, $urandom);
    add_item(sws_pkg::CMD_SEARCH, $urandom, 32'h8000_0000);
    add_item(sws_pkg::CMD_SEARCH, $urandom, 32'h7fff_ffff);
    add_item(sws_pkg::CMD_SEARCH, $urandom, 32'h0000_0000);
    add_item(sws_pkg::CMD_POP, $urandom, $urandom);
    add_item(sws_pkg::CMD_PUSH, 32'h8000_0000, $urandom);
    for (n = 0; n < StackDepth - 2; n++)
      add_item(sws_pkg::CMD_PUSH, (n == 0) ? 32'h0000_0000 : (n == 1) ? 32'hffff_ffff :
               32'h5a5a_0000 + n, $urandom);
    add_item(sws_pkg::CMD_PUSH, 32'h1234_5678, $urandom);
    add_item(sws_pkg::CMD_SEARCH, $urandom, 32'h7fff_ffff);
    add_item(CmdUnused, $urandom, $urandom);
    add_item(sws_pkg::CMD_POP, $urandom, $urandom);

    mode_left = 0;
    push_bias = 75;
    n = 0;
    while (n < RandomItems) begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 80);
        push_bias = (push_bias == 75) ? 25 : 75;
      end
      mode_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        cmd = CmdUnused;
      end else begin
        n++;
        if (roll < 33) cmd = sws_pkg::CMD_SEARCH;
        else if ($urandom_range(0, 99) < push_bias) cmd = sws_pkg::CMD_PUSH;
        else cmd = sws_pkg::CMD_POP;
      end
      add_item(cmd, pick_value(), pick_key(), n == RandomItems / 2 || n == 1);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (40) @(posedge clk_i);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
